>>> hw/rtl/qbre_pkg.sv
// qbre_pkg: shared types, constants and helpers of the quadtree bitmap run encoder.
// Used by qbre_layer_unit, qbre_layer_store and quadtree_bitmap_run_encoder_unit.
package qbre_pkg;

    localparam int NDIM           = 2;
    localparam int CODES_IN_WORD  = 1 << NDIM;
    localparam int WORD_BITS      = 2 * CODES_IN_WORD;
    localparam int RUN_W          = 33;
    localparam int SUM_W          = RUN_W + 1;
    localparam int LAYER_IDX_W    = 4;
    localparam int LAYERS_W       = 5;
    localparam int MAX_LAYERS_DEF = 16;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_LAYERS_IN_USE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DENSE_SUFFIX  = CFG_IDX_W'(1);

    localparam logic [LAYERS_W-1:0] LAYERS_RESET = LAYERS_W'(16);

    localparam logic [1:0] CODE_MIXED = 2'b10;
    localparam logic [1:0] CODE_ONE   = 2'b01;
    localparam logic [1:0] CODE_ZERO  = 2'b00;

    typedef struct packed {
        logic [RUN_W-1:0] run_length;
        logic             bit_value;
    } t_in_item;

    typedef struct packed {
        logic [LAYER_IDX_W-1:0] layer_index;
        logic [WORD_BITS-1:0]   code_word;
        logic                   to_dense_suffix;
        logic                   last;
    } t_out_item;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic [NDIM-1:0]      len;
        logic [RUN_W-1:0]     count;
        logic                 bit_value;
        logic                 bottom;
        logic                 top;
        logic                 pure_in;
    } t_step_req;

    typedef struct packed {
        logic                 emit;
        logic                 carry;
        logic                 pure_word;
        logic [WORD_BITS-1:0] word;
        logic [RUN_W-1:0]     count_out;
        logic [WORD_BITS-1:0] new_word;
        logic [NDIM-1:0]      new_len;
    } t_step_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FLUSH
    } t_state;

    function automatic logic [WORD_BITS-1:0] fill_word(input logic [1:0] code);
        logic [WORD_BITS-1:0] w;
        w = '0;
        for (int i = 0; i < CODES_IN_WORD; i++) begin
            w[2*i +: 2] = code;
        end
        return w;
    endfunction

endpackage

>>> hw/rtl/qbre_layer_unit.sv
// qbre_layer_unit: one layer step, shared by all layers under the sequencer.
// Merges codes into the layer word, adds the run, decides carry and emission.
// Depends on qbre_pkg.
module qbre_layer_unit (
    input  qbre_pkg::t_step_req i_req,
    output qbre_pkg::t_step_res o_res
);

    logic [1:0]                     run_code;
    logic [qbre_pkg::WORD_BITS-1:0] run_mask;
    logic [1:0]                     ins_code;
    logic [qbre_pkg::WORD_BITS-1:0] w1;
    logic [qbre_pkg::NDIM:0]        len1;
    logic [qbre_pkg::SUM_W-1:0]     sum;
    logic                           carry;
    logic                           word_pure;
    logic [qbre_pkg::NDIM-1:0]      new_len;
    logic [qbre_pkg::WORD_BITS-1:0] keep_mask;

    always_comb begin
        run_code = i_req.bit_value ? qbre_pkg::CODE_ONE : qbre_pkg::CODE_ZERO;
        run_mask = qbre_pkg::fill_word(run_code);
        ins_code = i_req.pure_in ? run_code : qbre_pkg::CODE_MIXED;
        if (i_req.bottom) begin
            w1   = i_req.word | (run_mask << {i_req.len, 1'b0});
            len1 = {1'b0, i_req.len};
        end else begin
            w1   = i_req.word
                 | (qbre_pkg::WORD_BITS'(ins_code) << {i_req.len, 1'b0});
            len1 = {1'b0, i_req.len} + (qbre_pkg::NDIM+1)'(1);
            if (len1 < (qbre_pkg::NDIM+1)'(qbre_pkg::CODES_IN_WORD)) begin
                w1 = w1 | (run_mask << {len1, 1'b0});
            end
        end
        sum       = qbre_pkg::SUM_W'(i_req.count) + qbre_pkg::SUM_W'(len1);
        carry     = |sum[qbre_pkg::SUM_W-1:qbre_pkg::NDIM];
        word_pure = (w1 == run_mask);
        new_len   = sum[qbre_pkg::NDIM-1:0];
        keep_mask = ~({qbre_pkg::WORD_BITS{1'b1}} << {new_len, 1'b0});

        o_res.emit      = carry && (!word_pure || i_req.top);
        o_res.carry     = carry;
        o_res.pure_word = word_pure;
        o_res.word      = w1;
        o_res.count_out = qbre_pkg::RUN_W'((sum >> qbre_pkg::NDIM) - qbre_pkg::SUM_W'(1));
        o_res.new_word  = (carry ? run_mask : w1) & keep_mask;
        o_res.new_len   = new_len;
    end

endmodule

>>> hw/rtl/qbre_layer_store.sv
// qbre_layer_store: partial word and code count of every layer, cleared by reset.
// One read and one write port at the sequencer's layer. Depends on qbre_pkg.
module qbre_layer_store #(
    parameter int DEPTH = qbre_pkg::MAX_LAYERS_DEF,
    parameter int AW    = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [AW-1:0]                  i_addr,
    input  logic                           i_we,
    input  logic [qbre_pkg::WORD_BITS-1:0] i_wword,
    input  logic [qbre_pkg::NDIM-1:0]      i_wlen,
    output logic [qbre_pkg::WORD_BITS-1:0] o_rword,
    output logic [qbre_pkg::NDIM-1:0]      o_rlen
);

    logic [qbre_pkg::WORD_BITS-1:0] r_word [DEPTH];
    logic [qbre_pkg::NDIM-1:0]      r_len  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_word[i] <= '0;
                r_len[i]  <= '0;
            end
        end else if (i_we) begin
            r_word[i_addr] <= i_wword;
            r_len[i_addr]  <= i_wlen;
        end
    end

    assign o_rword = r_word[i_addr];
    assign o_rlen  = r_len[i_addr];

endmodule

>>> hw/rtl/quadtree_bitmap_run_encoder_unit.sv
// Quadtree bitmap run encoder: turns runs of equal bits into compressed linear quadtree
// words, one 2-bit code per subtree. A run with nonzero length is taken and then walks
// the layers from the bottom with a single layer-step unit, one layer per cycle while
// no pending word waits on a stalled output, until the carry stops or the top layer in
// use is reached: at most N layers, N being layers_in_use with zero read as one and
// capped at MAX_LAYERS. The final word, if any, is released from the flush state, which
// waits while the output stalls. A zero-length run gives no word. Input stall is high
// while a run is in work, and register writes are taken only while no run is in work.
// Depends on qbre_pkg, qbre_layer_unit and qbre_layer_store.
module quadtree_bitmap_run_encoder_unit #(
    parameter int MAX_LAYERS = qbre_pkg::MAX_LAYERS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  qbre_pkg::t_in_item              i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output qbre_pkg::t_out_item             o_out_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [qbre_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [qbre_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int TW = qbre_pkg::LAYERS_W + 1;

    qbre_pkg::t_state    r_state, n_state;
    logic [qbre_pkg::LAYERS_W-1:0] r_layers;
    logic                r_dense;
    logic [LW-1:0]       r_layer;
    logic [qbre_pkg::RUN_W-1:0] r_count;
    logic                r_bit;
    logic                r_pure;
    qbre_pkg::t_out_item r_pend;
    logic                r_pend_valid;
    qbre_pkg::t_out_item r_out;
    logic                r_out_valid;

    qbre_pkg::t_step_req req;
    qbre_pkg::t_step_res res;
    qbre_pkg::t_out_item new_item;
    qbre_pkg::t_out_item push_item;
    logic [qbre_pkg::WORD_BITS-1:0] st_word;
    logic [qbre_pkg::NDIM-1:0]      st_len;
    logic [TW-1:0]       lim;
    logic                is_top;
    logic                out_free;
    logic                in_accept;
    logic                commit;
    logic                run_done;
    logic                flush_go;
    logic                push_out;

    qbre_layer_store #(
        .DEPTH (MAX_LAYERS),
        .AW    (LW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_addr  (r_layer),
        .i_we    (commit),
        .i_wword (res.new_word),
        .i_wlen  (res.new_len),
        .o_rword (st_word),
        .o_rlen  (st_len)
    );

    qbre_layer_unit u_unit (
        .i_req (req),
        .o_res (res)
    );

    always_comb begin
        lim = (r_layers == '0) ? TW'(1) : TW'(r_layers);
        if (lim > TW'(MAX_LAYERS)) begin
            lim = TW'(MAX_LAYERS);
        end
        is_top = ((TW'(r_layer) + TW'(1)) == lim);
    end

    always_comb begin
        req.word      = st_word;
        req.len       = st_len;
        req.count     = r_count;
        req.bit_value = r_bit;
        req.bottom    = (r_layer == '0);
        req.top       = is_top;
        req.pure_in   = r_pure;

        new_item.layer_index     = qbre_pkg::LAYER_IDX_W'(r_layer);
        new_item.code_word       = res.word;
        new_item.to_dense_suffix = r_dense && (r_layer == '0);
        new_item.last            = 1'b0;

        push_item      = r_pend;
        push_item.last = flush_go;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            qbre_pkg::S_IDLE: begin
                if (in_accept && (i_in_item.run_length != '0)) begin
                    n_state = qbre_pkg::S_RUN;
                end
            end
            qbre_pkg::S_RUN: begin
                if (commit && run_done) begin
                    n_state = (r_pend_valid || res.emit) ? qbre_pkg::S_FLUSH
                                                         : qbre_pkg::S_IDLE;
                end
            end
            qbre_pkg::S_FLUSH: begin
                if (out_free) begin
                    n_state = qbre_pkg::S_IDLE;
                end
            end
            default: n_state = qbre_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        out_free  = !r_out_valid || !i_out_stall;
        in_accept = i_in_valid && (r_state == qbre_pkg::S_IDLE);
        commit    = (r_state == qbre_pkg::S_RUN)
                 && !(res.emit && r_pend_valid && !out_free);
        run_done  = !res.carry || is_top;
        flush_go  = (r_state == qbre_pkg::S_FLUSH) && out_free;
        push_out  = (commit && res.emit && r_pend_valid) || flush_go;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= qbre_pkg::S_IDLE;
            r_layers     <= qbre_pkg::LAYERS_RESET;
            r_dense      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    qbre_pkg::CFG_LAYERS_IN_USE: r_layers <= i_cfg_data;
                    qbre_pkg::CFG_DENSE_SUFFIX:  r_dense  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (commit && res.emit) begin
                r_pend_valid <= 1'b1;
            end else if (flush_go) begin
                r_pend_valid <= 1'b0;
            end
            if (push_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_count <= i_in_item.run_length;
            r_bit   <= i_in_item.bit_value;
            r_layer <= '0;
            r_pure  <= 1'b0;
        end else if (commit) begin
            r_count <= res.count_out;
            r_pure  <= res.pure_word;
            if (!run_done) begin
                r_layer <= r_layer + LW'(1);
            end
        end
        if (commit && res.emit) begin
            r_pend <= new_item;
        end
        if (push_out) begin
            r_out <= push_item;
        end
    end

    assign o_in_stall  = (r_state != qbre_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = (r_state == qbre_pkg::S_IDLE);

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qbre_pkg::S_IDLE) |-> !r_pend_valid)
        else $error("pending word left over in idle");

    a_flush_has_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qbre_pkg::S_FLUSH) |-> r_pend_valid)
        else $error("flush without pending word");

    a_layer_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == qbre_pkg::S_RUN) |-> (TW'(r_layer) < lim))
        else $error("layer beyond layers in use");

    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_in_item.run_length != '0)) |=> (r_state == qbre_pkg::S_RUN))
        else $error("nonzero run did not start the layer walk");

endmodule

>>> sim/qbre_run_encoder_checker.sv
`timescale 1ns / 1ps
// qbre_run_encoder_checker: watches the run, word and register channels of the quadtree
// bitmap run encoder, predicts the code words of every run and compares them as they leave.
// Depends on qbre_pkg.
module qbre_run_encoder_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  qbre_pkg::t_in_item              i_in_item,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  qbre_pkg::t_out_item             i_out_item,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [qbre_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [qbre_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int LAYER_CNT = qbre_pkg::MAX_LAYERS_DEF;

    logic [qbre_pkg::WORD_BITS-1:0] layer_word [LAYER_CNT];
    logic [qbre_pkg::NDIM-1:0]      layer_len  [LAYER_CNT];
    logic [qbre_pkg::LAYERS_W-1:0]  layers_cfg;
    logic                           dense_cfg;
    qbre_pkg::t_out_item            word_queue [$];
    int                             fails = 0;

    task automatic encode_run(input qbre_pkg::t_in_item run);
        logic [qbre_pkg::SUM_W:0]       remain;
        logic [qbre_pkg::SUM_W:0]       len;
        logic [1:0]                     run_code;
        logic [qbre_pkg::WORD_BITS-1:0] run_mask;
        logic [qbre_pkg::WORD_BITS-1:0] w;
        logic [qbre_pkg::WORD_BITS-1:0] code;
        logic                           was_pure;
        logic                           carry;
        logic                           have_held;
        int                             top;
        qbre_pkg::t_out_item            held;
        remain    = {2'b00, run.run_length};
        run_code  = run.bit_value ? qbre_pkg::CODE_ONE : qbre_pkg::CODE_ZERO;
        run_mask  = {qbre_pkg::CODES_IN_WORD{run_code}};
        was_pure  = 1'b0;
        have_held = 1'b0;
        held      = '0;
        top       = int'(layers_cfg);
        if (top < 1) top = 1;
        if (top > LAYER_CNT) top = LAYER_CNT;
        if (remain != 0) begin
            for (int layer = 0; layer < top; layer++) begin
                w     = layer_word[layer];
                len   = (qbre_pkg::SUM_W + 1)'(layer_len[layer]);
                carry = 1'b0;
                if (layer > 0) begin
                    // one code from the layer below, then the run continues
                    code = qbre_pkg::WORD_BITS'(was_pure ? run_code : qbre_pkg::CODE_MIXED);
                    w    = w | (code << (2 * len));
                    len  = len + 1;
                    if (len < qbre_pkg::CODES_IN_WORD) w = w | (run_mask << (2 * len));
                end else begin
                    w = w | (run_mask << (2 * len));
                end
                len = len + remain;
                if (len >= qbre_pkg::CODES_IN_WORD) begin
                    carry    = 1'b1;
                    was_pure = (w == run_mask);
                    if (!was_pure || layer == top - 1) begin
                        if (have_held) word_queue = {word_queue, held};
                        held.layer_index     = qbre_pkg::LAYER_IDX_W'(layer);
                        held.code_word       = w;
                        held.to_dense_suffix = dense_cfg && (layer == 0);
                        held.last            = 1'b0;
                        have_held            = 1'b1;
                    end
                    w      = run_mask;
                    remain = len / qbre_pkg::CODES_IN_WORD - 1;
                    len    = len % qbre_pkg::CODES_IN_WORD;
                end
                w = w & ((qbre_pkg::WORD_BITS'(1) << (2 * len)) - qbre_pkg::WORD_BITS'(1));
                layer_word[layer] = w;
                layer_len[layer]  = len[qbre_pkg::NDIM-1:0];
                if (!carry) break;
            end
            if (have_held) begin
                held.last  = 1'b1;
                word_queue = {word_queue, held};
            end
        end
    endtask

    task automatic check_word(input qbre_pkg::t_out_item got);
        qbre_pkg::t_out_item want;
        if (word_queue.size() == 0) begin
            $display("%0t: unexpected word: layer %0d code %02h dense %0b last %0b",
                     $time, got.layer_index, got.code_word, got.to_dense_suffix, got.last);
            fails++;
        end else begin
            want = word_queue.pop_front();
            if (got.layer_index !== want.layer_index || got.code_word !== want.code_word ||
                got.to_dense_suffix !== want.to_dense_suffix || got.last !== want.last) begin
                $display("%0t: word mismatch: expected layer %0d code %02h dense %0b last %0b",
                         $time, want.layer_index, want.code_word, want.to_dense_suffix,
                         want.last);
                $display("%0t:                  actual layer %0d code %02h dense %0b last %0b",
                         $time, got.layer_index, got.code_word, got.to_dense_suffix, got.last);
                fails++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAYER_CNT; i++) begin
                layer_word[i] = '0;
                layer_len[i]  = '0;
            end
            layers_cfg = qbre_pkg::LAYERS_RESET;
            dense_cfg  = 1'b0;
            word_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    qbre_pkg::CFG_LAYERS_IN_USE:
                        layers_cfg = i_cfg_data[qbre_pkg::LAYERS_W-1:0];
                    qbre_pkg::CFG_DENSE_SUFFIX:
                        dense_cfg  = i_cfg_data[0];
                    default: ;
                endcase
            end
            // predict first: a word can never precede its run in the queue
            if (i_in_valid && !i_in_stall) encode_run(i_in_item);
            if (i_out_valid && !i_out_stall) check_word(i_out_item);
        end
        o_fail_count <= fails;
        o_pending    <= word_queue.size();
    end

endmodule

>>> sim/quadtree_bitmap_run_encoder_unit_tb.sv
`timescale 1ns / 1ps
// quadtree_bitmap_run_encoder_unit_tb: drives runs and register writes into the encoder
// with random gaps and output stalls, and reports the verdict of qbre_run_encoder_checker.
// Depends on qbre_pkg, qbre_run_encoder_checker and quadtree_bitmap_run_encoder_unit.
module quadtree_bitmap_run_encoder_unit_tb;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = qbre_pkg::MAX_LAYERS_DEF + 8;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 24;

    localparam logic [qbre_pkg::CFG_IDX_W-1:0] CFG_UNUSED = qbre_pkg::CFG_IDX_W'(15);
    localparam logic [qbre_pkg::RUN_W-1:0]     RUN_MAX    =
        qbre_pkg::RUN_W'(64'h1_0000_0000);

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            in_valid    = 1'b0;
    logic                            in_stall;
    qbre_pkg::t_in_item              in_item     = '0;
    logic                            out_valid;
    logic                            out_stall   = 1'b0;
    qbre_pkg::t_out_item             out_item;
    logic                            cfg_valid   = 1'b0;
    logic                            cfg_ready;
    logic [qbre_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [qbre_pkg::CFG_DATA_W-1:0] cfg_data    = '0;
    logic                            quiet       = 1'b0;
    int                              fail_count;
    int                              pending;
    int                              cycle_count = 0;

    quadtree_bitmap_run_encoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    qbre_run_encoder_checker word_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("quadtree_bitmap_run_encoder_unit regression: fail");
            $finish;
        end
    end

    initial begin : out_stall_gen
        int left;
        left = 0;
        forever begin
            @(negedge i_clk);
            if (quiet) begin
                out_stall = 1'b0;
                left      = 0;
            end else if (left > 0) begin
                left--;
                if (left == 0) out_stall = 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                out_stall = 1'b1;
                left      = $urandom_range(1, 18);
            end else begin
                out_stall = 1'b0;
            end
        end
    end

    task automatic send_run(input logic [qbre_pkg::RUN_W-1:0] len, input logic bit_val);
        int gap;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap      = $urandom_range(1, 18);
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid           = 1'b1;
        in_item.run_length = len;
        in_item.bit_value  = bit_val;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_valid = 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [qbre_pkg::CFG_IDX_W-1:0] idx,
                             input logic [qbre_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [qbre_pkg::RUN_W-1:0] pick_length();
        int                         sel;
        logic [qbre_pkg::RUN_W-1:0] v;
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
            v = '0;
        end else if (sel < 55) begin
            v = qbre_pkg::RUN_W'($urandom_range(1, 12));
        end else if (sel < 75) begin
            v = qbre_pkg::RUN_W'(1) << (2 * $urandom_range(0, 16));
        end else if (sel < 85) begin
            v = (qbre_pkg::RUN_W'(1) << (2 * $urandom_range(1, 15)))
              + qbre_pkg::RUN_W'($urandom_range(1, 7));
        end else if (sel < 97) begin
            v = {1'b0, 32'($urandom)};
        end else begin
            v = RUN_MAX;
        end
        return v;
    endfunction

    function automatic logic [qbre_pkg::CFG_DATA_W-1:0] pick_layers();
        logic [qbre_pkg::CFG_DATA_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = qbre_pkg::CFG_DATA_W'(16);
            1:       v = qbre_pkg::CFG_DATA_W'(1);
            2:       v = qbre_pkg::CFG_DATA_W'(2);
            3:       v = qbre_pkg::CFG_DATA_W'(0);
            4:       v = qbre_pkg::CFG_DATA_W'(31);
            default: v = qbre_pkg::CFG_DATA_W'($urandom_range(0, 31));
        endcase
        return v;
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: all layers, no dense suffix
        send_run(qbre_pkg::RUN_W'(0), 1'b0);
        send_run(qbre_pkg::RUN_W'(0), 1'b1);
        send_run(qbre_pkg::RUN_W'(1), 1'b1);
        send_run(qbre_pkg::RUN_W'(1), 1'b0);
        send_run(qbre_pkg::RUN_W'(1), 1'b1);
        send_run(qbre_pkg::RUN_W'(1), 1'b0);
        send_run(qbre_pkg::RUN_W'(4), 1'b1);
        send_run(qbre_pkg::RUN_W'(3), 1'b0);
        send_run(qbre_pkg::RUN_W'(5), 1'b1);
        send_run(qbre_pkg::RUN_W'(16), 1'b0);
        send_run(qbre_pkg::RUN_W'(64), 1'b1);
        send_run(RUN_MAX, 1'b0);
        send_run(RUN_MAX, 1'b1);
        send_run(qbre_pkg::RUN_W'(32'hFFFF_FFFF), 1'b1);
        send_run(qbre_pkg::RUN_W'(2), 1'b0);
        send_run(qbre_pkg::RUN_W'(6), 1'b1);
        settle();

        // single layer: carry out of the top is dropped
        write_reg(qbre_pkg::CFG_DENSE_SUFFIX, qbre_pkg::CFG_DATA_W'(31));
        write_reg(qbre_pkg::CFG_LAYERS_IN_USE, qbre_pkg::CFG_DATA_W'(1));
        send_run(qbre_pkg::RUN_W'(1), 1'b1);
        send_run(qbre_pkg::RUN_W'(2), 1'b0);
        send_run(qbre_pkg::RUN_W'(4), 1'b1);
        send_run(qbre_pkg::RUN_W'(7), 1'b0);
        send_run(RUN_MAX, 1'b1);
        settle();

        // zero layers act as one, counts above the maximum saturate
        write_reg(qbre_pkg::CFG_LAYERS_IN_USE, qbre_pkg::CFG_DATA_W'(0));
        send_run(qbre_pkg::RUN_W'(3), 1'b1);
        send_run(qbre_pkg::RUN_W'(9), 1'b0);
        settle();
        write_reg(qbre_pkg::CFG_LAYERS_IN_USE, qbre_pkg::CFG_DATA_W'(31));
        write_reg(CFG_UNUSED, qbre_pkg::CFG_DATA_W'(10));
        send_run(qbre_pkg::RUN_W'(1), 1'b0);
        send_run(RUN_MAX, 1'b1);
        send_run(qbre_pkg::RUN_W'(5), 1'b1);
        settle();

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            if (phase == RAND_PHASES - 1) begin
                quiet = 1'b1;
                write_reg(qbre_pkg::CFG_LAYERS_IN_USE, qbre_pkg::CFG_DATA_W'(16));
            end else begin
                write_reg(qbre_pkg::CFG_LAYERS_IN_USE, pick_layers());
            end
            write_reg(qbre_pkg::CFG_DENSE_SUFFIX,
                      qbre_pkg::CFG_DATA_W'($urandom_range(0, 31)));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_run(pick_length(), 1'($urandom_range(0, 1)));
            end
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("quadtree_bitmap_run_encoder_unit regression: pass");
        end else begin
            $display("quadtree_bitmap_run_encoder_unit regression: fail");
        end
        $finish;
    end

endmodule
